@@ hdl/epdc_pkg.sv @@
package epdc_pkg;

    localparam int IV_BYTES    = 8;
    localparam int MAC_BYTES   = 6;
    localparam int ALIGN_BYTES = 16;

    localparam int HDR_LEN     = 8;
    localparam int TRAILER_LEN = 2;
    localparam int FIXED_LEN   = HDR_LEN + IV_BYTES + TRAILER_LEN + MAC_BYTES;

    localparam logic [15:0] HDR_LEN16     = 16'(HDR_LEN);
    localparam logic [15:0] IV_END16      = 16'(HDR_LEN + IV_BYTES);
    localparam logic [15:0] MAC_BYTES16   = 16'(MAC_BYTES);
    localparam logic [15:0] TRAILER_LEN16 = 16'(TRAILER_LEN);
    localparam logic [15:0] FIXED_LEN16   = 16'(FIXED_LEN);
    localparam logic [15:0] ALIGN16       = 16'(ALIGN_BYTES);
    localparam logic [15:0] SPI_LAST16    = 16'd3;
    localparam logic [15:0] SPI_END16     = 16'd4;
    localparam logic [15:0] SEQ_LOW16     = 16'(HDR_LEN - 1);
    localparam logic [15:0] POS_MAX16     = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_SPI = 1'b0,
        CFG_KEY_SEED     = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_PASS   = 3'd0,
        ST_LENGTH = 3'd1,
        ST_SPI    = 3'd2,
        ST_IV     = 3'd3,
        ST_MAC    = 3'd4,
        ST_PAD    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        KIND_SPI  = 3'd0,
        KIND_HDR  = 3'd1,
        KIND_KEY  = 3'd2,
        KIND_IV   = 3'd3,
        KIND_BODY = 3'd4,
        KIND_MAC  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0]  data;
        kind_t       kind;
        logic        in_range;
        logic        spi_last;
        logic        pad_pos;
        logic        proto_pos;
        logic        len_fail;
        logic        last;
        logic        count_mismatch;
        logic [15:0] body_len;
    } cmd_t;

endpackage

@@ hdl/esp_packet_decapsulate_check_top.sv @@
// Channel   Handshake            Payload
// input     in_valid / in_stall  in_byte, packet_len, last_byte
// output    out_valid / out_stall out_byte, status_valid, status_code, payload_len,
//                                next_protocol
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; each request passes through
// a four-entry command queue and then the output register before its result is shown.
// Sustained rate is one byte per cycle while out_stall is low, set by the back-end update.
// Reset clears all packet state, the queue and both configuration registers.
// A stall on the output fills the queue; in_stall rises only when it is full.
module esp_packet_decapsulate_check_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [7:0]                      in_byte,
    input  logic [15:0]                     packet_len,
    input  logic                            last_byte,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic [7:0]                      out_byte,
    output logic                            status_valid,
    output logic [2:0]                      status_code,
    output logic [15:0]                     payload_len,
    output logic [7:0]                      next_protocol,
    output logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [epdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import epdc_pkg::*;

    logic [31:0] expected_spi_reg;
    logic [7:0]  key_seed_reg;

    logic        q_full;
    logic        push;
    cmd_t        push_cmd;
    logic        pop;
    logic        head_valid;
    cmd_t        head_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_spi_reg <= '0;
            key_seed_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_EXPECTED_SPI: expected_spi_reg <= cfg_data;
                CFG_KEY_SEED:     key_seed_reg     <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    epdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .packet_len (packet_len),
        .last_byte  (last_byte),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    epdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    epdc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .expected_spi  (expected_spi_reg),
        .key_seed      (key_seed_reg),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_byte      (out_byte),
        .status_valid  (status_valid),
        .status_code   (status_code),
        .payload_len   (payload_len),
        .next_protocol (next_protocol),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

endmodule

@@ hdl/epdc_front.sv @@
module epdc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  logic [15:0]         packet_len,
    input  logic                last_byte,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                q_full,
    output logic                push,
    output epdc_pkg::cmd_t      cmd
);
    import epdc_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] held_now;
    logic [15:0] mac_start;
    logic [15:0] align_val;
    logic        first;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign first     = (pos_reg == '0);
    assign held_now  = first ? packet_len : held_reg;
    assign mac_start = held_now - MAC_BYTES16;
    assign align_val = packet_len - FIXED_LEN16 + TRAILER_LEN16;

    always_comb
    begin
        cmd.data     = in_byte;
        cmd.in_range = (pos_reg < held_now);
        cmd.spi_last = (pos_reg == SPI_LAST16);
        cmd.pad_pos  = (pos_reg == mac_start - 16'd2);
        cmd.proto_pos = (pos_reg == mac_start - 16'd1);
        cmd.len_fail = first && ((packet_len < FIXED_LEN16) ||
                                 ((align_val % ALIGN16) != '0));
        cmd.last     = last_byte;
        cmd.count_mismatch = ({1'b0, pos_reg} + 17'd1) != {1'b0, held_now};
        cmd.body_len = held_now - FIXED_LEN16;
        if (pos_reg < SPI_END16)
            cmd.kind = KIND_SPI;
        else if (pos_reg == SEQ_LOW16)
            cmd.kind = KIND_KEY;
        else if (pos_reg < HDR_LEN16)
            cmd.kind = KIND_HDR;
        else if (pos_reg < IV_END16)
            cmd.kind = KIND_IV;
        else if (pos_reg < mac_start)
            cmd.kind = KIND_BODY;
        else
            cmd.kind = KIND_MAC;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        held_next = held_reg;
        if (push)
        begin
            if (last_byte)
            begin
                pos_next  = '0;
                held_next = '0;
            end
            else
            begin
                held_next = held_now;
                if (pos_reg != POS_MAX16)
                    pos_next = pos_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ hdl/epdc_queue.sv @@
module epdc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  epdc_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output epdc_pkg::cmd_t      head_cmd
);
    import epdc_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/epdc_back.sv @@
module epdc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         expected_spi,
    input  logic [7:0]          key_seed,
    input  logic                head_valid,
    input  epdc_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic [7:0]          out_byte,
    output logic                status_valid,
    output logic [2:0]          status_code,
    output logic [15:0]         payload_len,
    output logic [7:0]          next_protocol,
    output logic                out_valid,
    input  logic                out_stall
);
    import epdc_pkg::*;

    logic [31:0] spi_reg, spi_next;
    logic [7:0]  key_reg, key_next;
    status_t     failed_reg, failed_next;
    logic [7:0]  pad_reg, pad_next;
    logic [7:0]  proto_reg, proto_next;
    logic        out_valid_reg;

    logic [7:0]  ob;
    status_t     code;
    logic [15:0] dlen;
    logic [7:0]  proto_out;

    logic [7:0]  ob_reg;
    logic        last_reg;
    status_t     code_reg;
    logic [15:0] dlen_reg;
    logic [7:0]  proto_out_reg;

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        spi_next    = spi_reg;
        key_next    = key_reg;
        failed_next = head_cmd.len_fail ? ST_LENGTH : failed_reg;
        pad_next    = pad_reg;
        proto_next  = proto_reg;
        ob          = head_cmd.data;
        code        = ST_PASS;
        dlen        = '0;
        proto_out   = '0;

        if (failed_next == ST_PASS && head_cmd.in_range)
        begin
            unique case (head_cmd.kind)
                KIND_SPI:
                begin
                    spi_next = {head_cmd.data, spi_reg[31:8]};
                    if (head_cmd.spi_last && spi_next != expected_spi)
                        failed_next = ST_SPI;
                end
                KIND_KEY:
                    key_next = key_seed + head_cmd.data;
                KIND_IV:
                    if (head_cmd.data != key_reg)
                        failed_next = ST_IV;
                KIND_BODY:
                begin
                    ob = head_cmd.data ^ key_reg;
                    if (head_cmd.pad_pos)
                        pad_next = ob;
                    else if (head_cmd.proto_pos)
                        proto_next = ob;
                end
                KIND_MAC:
                    if (head_cmd.data != key_reg)
                        failed_next = ST_MAC;
                default:
                    ;
            endcase
        end

        if (head_cmd.last)
        begin
            if (failed_next == ST_PASS && head_cmd.count_mismatch)
                failed_next = ST_LENGTH;
            if (failed_next == ST_PASS && {8'd0, pad_next} > head_cmd.body_len)
                failed_next = ST_PAD;
            code = failed_next;
            if (failed_next == ST_PASS)
            begin
                dlen      = head_cmd.body_len - {8'd0, pad_next};
                proto_out = proto_next;
            end
            // The packet is finished, so every per-packet value starts over.
            spi_next    = '0;
            key_next    = '0;
            failed_next = ST_PASS;
            pad_next    = '0;
            proto_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_reg       <= '0;
            key_reg       <= '0;
            failed_reg    <= ST_PASS;
            pad_reg       <= '0;
            proto_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                spi_reg    <= spi_next;
                key_reg    <= key_next;
                failed_reg <= failed_next;
                pad_reg    <= pad_next;
                proto_reg  <= proto_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ob_reg        <= ob;
            last_reg      <= head_cmd.last;
            code_reg      <= code;
            dlen_reg      <= dlen;
            proto_out_reg <= proto_out;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = ob_reg;
    assign status_valid  = last_reg;
    assign status_code   = code_reg;
    assign payload_len   = dlen_reg;
    assign next_protocol = proto_out_reg;

endmodule
